>>> src/cist_pkg.sv
// Shared types and constants for the CAN identifier statistics table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cist_pkg;

   // field widths fixed by the word formats
   localparam int OP_W     = 2;
   localparam int ID_W     = 29;
   localparam int LEN_W    = 7;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;

   // defaults for the top-level parameters
   localparam int DEF_SLOTS       = 32;
   localparam int DEF_MAX_PAYLOAD = 64;

   typedef enum logic [OP_W-1:0] {
      OP_FRAME = 2'd0,
      OP_ERROR = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED = 3'd0,
      ST_NEW     = 3'd1,
      ST_FULL    = 3'd2,
      ST_ERROR   = 3'd3,
      ST_READ    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_UPDATE,
      S_ERROR,
      S_READ
   } state_type;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [LEN_W-1:0]   len;
      logic [TIME_W-1:0]  last_seen;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] snap;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic commit_frame;
      logic commit_error;
      logic commit_read;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            scan_end;
   } stat_type;

   // result word payload
   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot_index;
      logic               slot_used;
      logic [ID_W-1:0]    slot_id;
      logic [LEN_W-1:0]   slot_length;
      logic [COUNT_W-1:0] total_count;
      logic [COUNT_W-1:0] count_delta;
      logic [TIME_W-1:0]  age_ms;
      logic [COUNT_W-1:0] error_total;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> src/cist_req_if.sv
// Request channel interface: valid/ready plus the request word fields.
// Depends on cist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cist_req_if import cist_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ID_W-1:0]   frame_id;
   logic [LEN_W-1:0]  frame_length;
   logic [TIME_W-1:0] now_ms;
   logic [SLOT_W-1:0] read_slot;

   modport source (
      output valid, opcode, frame_id, frame_length, now_ms, read_slot,
      input  ready
   );

   modport sink (
      input  valid, opcode, frame_id, frame_length, now_ms, read_slot,
      output ready
   );

endinterface

`default_nettype wire

>>> src/cist_rsp_if.sv
// Response channel interface: valid/ready plus the result word fields.
// Depends on cist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cist_rsp_if import cist_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic                slot_used;
   logic [ID_W-1:0]     slot_id;
   logic [LEN_W-1:0]    slot_length;
   logic [COUNT_W-1:0]  total_count;
   logic [COUNT_W-1:0]  count_delta;
   logic [TIME_W-1:0]   age_ms;
   logic [COUNT_W-1:0]  error_total;

   modport source (
      output valid, status, slot_index, slot_used, slot_id, slot_length,
             total_count, count_delta, age_ms, error_total,
      input  ready
   );

   modport sink (
      input  valid, status, slot_index, slot_used, slot_id, slot_length,
             total_count, count_delta, age_ms, error_total,
      output ready
   );

endinterface

`default_nettype wire

>>> src/can_id_statistics_table.sv
// CAN identifier statistics table, top level.
// Channels: req_if (sink) takes request words, rsp_if (source) gives one result word
// per frame, error or read request; opcode 3 is dropped without a result.
// A frame word is matched against the used slots by a linear scan of the slot
// memory, one slot per cycle; a hit updates length, last-seen time and count,
// a miss takes the lowest free slot, and a full table drops the frame.
// An error word bumps the saturating error counter. A read word returns the
// slot's figures and snapshots its count for the next delta.
// From acceptance to rsp valid, a frame word passes the dispatch, scan and update
// states, and an error or read word the dispatch state and its error or read state.
// The scan over the single read port of the slot memory is the longest part and
// ends early on a match. The next word is taken the cycle after a commit.
// One word is in work at a time; req_ready is high only between words. A
// finished result sits in the output register, so the next word is taken
// while it waits; a stalled receiver holds the block before its next commit.
// Reset clears all slot valid bits, the error counter and the handshakes;
// slot memory contents are ignored until a slot is allocated.
// Depends on cist_pkg, cist_req_if, cist_rsp_if, cist_controller, cist_datapath.
`timescale 1ns / 1ps
`default_nettype none

module can_id_statistics_table import cist_pkg::*; #(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   cist_req_if.sink   req_if,
   cist_rsp_if.source rsp_if
);

   cmd_type      cmd;
   stat_type     stat;
   rsp_word_type rsp_word;

   // sequencing and handshakes
   cist_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage, scan and result word
   cist_datapath #(
      .SLOTS       (SLOTS),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_if.opcode),
      .req_frame_id     (req_if.frame_id),
      .req_frame_length (req_if.frame_length),
      .req_now_ms       (req_if.now_ms),
      .req_read_slot    (req_if.read_slot),
      .rsp_word         (rsp_word)
   );

   assign rsp_if.status      = rsp_word.status;
   assign rsp_if.slot_index  = rsp_word.slot_index;
   assign rsp_if.slot_used   = rsp_word.slot_used;
   assign rsp_if.slot_id     = rsp_word.slot_id;
   assign rsp_if.slot_length = rsp_word.slot_length;
   assign rsp_if.total_count = rsp_word.total_count;
   assign rsp_if.count_delta = rsp_word.count_delta;
   assign rsp_if.age_ms      = rsp_word.age_ms;
   assign rsp_if.error_total = rsp_word.error_total;

endmodule

`default_nettype wire

>>> src/cist_datapath.sv
// Datapath: request register, slot memory, valid bits, scan pipeline,
// error counter and result register. Depends on cist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cist_datapath import cist_pkg::*; #(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [ID_W-1:0]   req_frame_id,
   input  logic [LEN_W-1:0]  req_frame_length,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [SLOT_W-1:0] req_read_slot,
   output rsp_word_type      rsp_word
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SLOTS);
   localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_PAYLOAD);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   // captured request word
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SLOT_W-1:0] slot_ff;

   // table state
   entry_type          mem [SLOTS];
   entry_type          rd_data_ff;
   logic [SLOTS-1:0]   slot_valid_ff;
   logic [COUNT_W-1:0] err_ff;
   logic [COUNT_W-1:0] err_in;

   // scan pipeline
   logic [SCAN_W-1:0] scan_ff;
   logic              cmp_live_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              hit_found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   entry_type         hit_entry_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   logic             scan_more;
   logic             issue;
   logic [IDX_W-1:0] rd_idx;
   logic             cmp_hit;
   logic             cmp_free;
   logic [IDX_W-1:0] req_idx;
   logic             read_ok;
   logic             read_hit;
   logic             frame_ok;
   logic [IDX_W-1:0] frame_slot;
   entry_type        frame_base;
   entry_type        frame_entry;
   entry_type        snap_entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;
   logic             rsp_load;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         id_ff   <= req_frame_id;
         len_ff  <= req_frame_length;
         now_ff  <= req_now_ms;
         slot_ff <= req_read_slot;
      end
   end

   // scan issue / compare
   assign scan_more = (scan_ff != SCAN_LAST);
   assign issue     = cmd.scan_step && scan_more;
   assign req_idx   = IDX_W'(slot_ff);
   assign rd_idx    = issue ? scan_ff[IDX_W-1:0] : req_idx;
   assign cmp_hit   = cmp_live_ff && slot_valid_ff[cmp_idx_ff] && (rd_data_ff.id == id_ff);
   assign cmp_free  = cmp_live_ff && !slot_valid_ff[cmp_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         cmp_live_ff   <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_ff       <= '0;
         cmp_live_ff   <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cmp_live_ff <= issue;
         if (issue) begin
            scan_ff <= scan_ff + SCAN_W'(1);
         end
         if (cmp_hit && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
         end
         if (cmp_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ff[IDX_W-1:0];
      if (cmp_hit && !hit_found_ff) begin
         hit_idx_ff   <= cmp_idx_ff;
         hit_entry_ff <= rd_data_ff;
      end
      if (cmp_free && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   // frame update: matched slot, else lowest free slot starting from zeros
   assign frame_ok   = hit_found_ff || free_found_ff;
   assign frame_slot = hit_found_ff ? hit_idx_ff : free_idx_ff;
   assign frame_base = hit_found_ff ? hit_entry_ff : '0;

   always_comb begin
      frame_entry           = frame_base;
      frame_entry.id        = id_ff;
      frame_entry.len       = (len_ff > LEN_CAP) ? LEN_CAP : len_ff;
      frame_entry.last_seen = now_ff;
      frame_entry.count     = sat_inc(frame_base.count);
   end

   // read: slot in range and in use
   assign read_ok  = (32'(slot_ff) < 32'(SLOTS));
   assign read_hit = read_ok && slot_valid_ff[req_idx];

   always_comb begin
      snap_entry      = rd_data_ff;
      snap_entry.snap = rd_data_ff.count;
   end

   assign wr_en   = (cmd.commit_frame && frame_ok) || (cmd.commit_read && read_hit);
   assign wr_idx  = cmd.commit_frame ? frame_slot : req_idx;
   assign wr_data = cmd.commit_frame ? frame_entry : snap_entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (cmd.commit_frame && frame_ok) begin
         slot_valid_ff[frame_slot] <= 1'b1;
      end
   end

   assign err_in = cmd.commit_error ? sat_inc(err_ff) : err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
      end else begin
         err_ff <= err_in;
      end
   end

   // result word
   always_comb begin
      rsp_word_in             = '0;
      rsp_word_in.error_total = err_in;
      priority if (cmd.commit_frame) begin
         if (frame_ok) begin
            rsp_word_in.status      = hit_found_ff ? ST_UPDATED : ST_NEW;
            rsp_word_in.slot_index  = SLOT_W'(frame_slot);
            rsp_word_in.slot_used   = 1'b1;
            rsp_word_in.slot_id     = frame_entry.id;
            rsp_word_in.slot_length = frame_entry.len;
            rsp_word_in.total_count = frame_entry.count;
            rsp_word_in.count_delta = frame_entry.count - frame_entry.snap;
         end else begin
            rsp_word_in.status = ST_FULL;
         end
      end else if (cmd.commit_error) begin
         rsp_word_in.status = ST_ERROR;
      end else begin
         rsp_word_in.status     = ST_READ;
         rsp_word_in.slot_index = slot_ff;
         if (read_hit) begin
            rsp_word_in.slot_used   = 1'b1;
            rsp_word_in.slot_id     = rd_data_ff.id;
            rsp_word_in.slot_length = rd_data_ff.len;
            rsp_word_in.total_count = rd_data_ff.count;
            rsp_word_in.count_delta = rd_data_ff.count - rd_data_ff.snap;
            rsp_word_in.age_ms      = now_ff - rd_data_ff.last_seen;
         end
      end
   end

   assign rsp_load = cmd.commit_frame || cmd.commit_error || cmd.commit_read;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word      = rsp_word_ff;
   assign stat.op       = op_ff;
   assign stat.scan_end = hit_found_ff || (!scan_more && !cmp_live_ff);

   // slots are never released outside reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) || (($past(slot_valid_ff) & ~slot_valid_ff) == '0))
      else $error("slot valid bit dropped");

   // at most one slot is allocated per step
   assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff & ~$past(slot_valid_ff)) <= 1)
      else $error("more than one slot allocated");

   // a drop only happens with the table full
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_frame && !hit_found_ff && !free_found_ff) |-> (&slot_valid_ff))
      else $error("frame dropped with a free slot");

   // a match always names a used slot
   assert property (@(posedge clock) disable iff (reset)
      hit_found_ff |-> slot_valid_ff[hit_idx_ff])
      else $error("match on an unused slot");

endmodule

`default_nettype wire

>>> src/cist_controller.sv
// Controller: sequences capture, scan and commit of one request word and
// owns the handshakes. Depends on cist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cist_controller import cist_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;
   logic      rsp_load;

   // result register can take a word this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_FRAME: state_in = S_SCAN;
               OP_ERROR: state_in = S_ERROR;
               OP_READ:  state_in = S_READ;
               default:  state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE, S_ERROR, S_READ: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DISPATCH: cmd.scan_start   = 1'b1;
         S_SCAN:     cmd.scan_step    = 1'b1;
         S_UPDATE:   cmd.commit_frame = rsp_free;
         S_ERROR:    cmd.commit_error = rsp_free;
         S_READ:     cmd.commit_read  = rsp_free;
         default:    cmd = '0;
      endcase
   end

   assign rsp_load = cmd.commit_frame || cmd.commit_error || cmd.commit_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a commit never overwrites a word still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result word overwritten");

   // new requests are only taken when idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_DISPATCH))
      else $error("capture outside idle");

   // at most one commit per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit_frame, cmd.commit_error, cmd.commit_read}))
      else $error("overlapping commits");

endmodule

`default_nettype wire
